@@ design/nsc_pkg.sv @@
package nsc_pkg;

	localparam int ID_CHARS_DEF = 5;

	// "GPRMC" right aligned; upper bytes used only when more id characters are configured
	localparam logic [63:0] ID_RESET_64 = 64'h0000_0047_5052_4D43;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SUM_BAD  = 2'd1;
	localparam logic [1:0] ST_ID_BAD   = 2'd2;
	localparam logic [1:0] ST_DIGIT_BAD = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
	} nsc_res_t;

endpackage

@@ design/nmea_sentence_checker.sv @@
// nmea sentence checker
// input channel rx_valid/rx_ready/rx_byte carries one character per word.
// a dollar starts or restarts a sentence; bytes up to the star are xored and
// the first ID_CHARS of them compared with sentence_id; the two bytes after
// the star are read as hex digits, high nibble first.
// after the low digit one word leaves on res_valid/res_ready with status,
// computed_sum and received_sum. other bytes give no output word.
// sentence_id is loaded on any cycle with sentence_id_we high; write it only
// while no sentence is in flight.
// a byte accepted into the input register is decoded from there and its result
// is loaded into the output register, where res_valid rises.
// throughput: one byte per cycle, set by the single input register feeding
// one combinational update of the parser state and the output register.
// while the output word is stalled, bytes that give no result keep flowing;
// a byte that would give a result waits in the input register and holds
// rx_ready low behind it.
// reset clears parser state and both valid flags and loads "GPRMC".
module nmea_sentence_checker import nsc_pkg::*; #(
	parameter int ID_CHARS = ID_CHARS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rx_valid,
	output logic                  rx_ready,
	input  logic [7:0]            rx_byte,
	input  logic                  sentence_id_we,
	input  logic [8*ID_CHARS-1:0] sentence_id,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [1:0]            status,
	output logic [7:0]            computed_sum,
	output logic [7:0]            received_sum
);

	logic [8*ID_CHARS-1:0] id_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  res_due;
	logic                  res_fire;
	logic                  s1_adv;
	nsc_res_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= ID_RESET_64[8*ID_CHARS-1:0];
		end else if (sentence_id_we) begin
			id_q <= sentence_id;
		end
	end

	nsc_parser #(
		.ID_CHARS(ID_CHARS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (s1_adv),
		.byte_in     (byte_s1),
		.sentence_id (id_q),
		.res_due     (res_due),
		.res_fire    (res_fire),
		.res         (res)
	);

	// a result-bearing byte may only go when the output register frees up
	assign s1_adv   = valid_s1 && !(res_valid && !res_ready && res_due);

	assign rx_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	nsc_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (res_fire),
		.res_in       (res),
		.res_ready    (res_ready),
		.res_valid    (res_valid),
		.status       (status),
		.computed_sum (computed_sum),
		.received_sum (received_sum)
	);

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !res_fire)
		else $error("result register overwritten while stalled");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(byte_s1))
		else $error("held byte lost");

	a_ok_sums: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_OK |-> computed_sum == received_sum)
		else $error("ok status with differing sums");

	a_bad_sums: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_SUM_BAD |-> computed_sum != received_sum)
		else $error("mismatch status with equal sums");
`endif

endmodule

@@ design/nsc_parser.sv @@
module nsc_parser import nsc_pkg::*; #(
	parameter int ID_CHARS = ID_CHARS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	input  logic [7:0]              byte_in,
	input  logic [8*ID_CHARS-1:0]   sentence_id,
	output logic                    res_due,
	output logic                    res_fire,
	output nsc_res_t                res
);

	localparam int PW = $clog2(ID_CHARS + 1);
	localparam int IW = (ID_CHARS > 1) ? $clog2(ID_CHARS) : 1;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;
	localparam logic [1:0] PH_LOW  = 2'd3;

	// bit 4 set when the byte is not a hex digit, value then zero
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'h10;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b0, 4'(b - 8'h30)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b0, 4'(b - 8'h37)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b0, 4'(b - 8'h57)};
		end
		return r;
	endfunction

	logic [1:0]    phase_q, phase_d;
	logic [7:0]    xor_q, xor_d;
	logic [PW-1:0] pos_q, pos_d;
	logic          match_q, match_d;
	logic [3:0]    high_q, high_d;
	logic          derr_q, derr_d;

	logic [7:0]    id_chars [ID_CHARS];
	logic [4:0]    dec;
	logic          pos_open;
	logic [7:0]    rx_sum;

	always_comb begin
		for (int k = 0; k < ID_CHARS; k++) begin
			id_chars[k] = sentence_id[8*(ID_CHARS-1-k) +: 8];
		end
	end

	assign dec      = hex_decode(byte_in);
	assign pos_open = pos_q < PW'(ID_CHARS);
	assign rx_sum   = {high_q, dec[3:0]};

	// the presented byte would close a sentence if taken
	assign res_due  = (phase_q == PH_LOW) && (byte_in != CH_DOLLAR);

	always_comb begin
		phase_d      = phase_q;
		xor_d        = xor_q;
		pos_d        = pos_q;
		match_d      = match_q;
		high_d       = high_q;
		derr_d       = derr_q;
		res_fire     = 1'b0;
		res.computed_sum = xor_q;
		res.received_sum = rx_sum;
		if (derr_q || dec[4]) begin
			res.status = ST_DIGIT_BAD;
		end else if (rx_sum != xor_q) begin
			res.status = ST_SUM_BAD;
		end else if (!match_q) begin
			res.status = ST_ID_BAD;
		end else begin
			res.status = ST_OK;
		end
		if (byte_valid) begin
			if (byte_in == CH_DOLLAR) begin
				phase_d = PH_BODY;
				xor_d   = '0;
				pos_d   = '0;
				match_d = 1'b1;
				high_d  = '0;
				derr_d  = 1'b0;
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_BODY: begin
						if (byte_in == CH_STAR) begin
							if (pos_open) begin
								match_d = 1'b0;
							end
							phase_d = PH_HIGH;
						end else begin
							xor_d = xor_q ^ byte_in;
							if (pos_open) begin
								if (byte_in != id_chars[pos_q[IW-1:0]]) begin
									match_d = 1'b0;
								end
								pos_d = pos_q + 1'b1;
							end
						end
					end
					PH_HIGH: begin
						high_d  = dec[3:0];
						derr_d  = derr_q | dec[4];
						phase_d = PH_LOW;
					end
					PH_LOW: begin
						res_fire = 1'b1;
						phase_d  = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			xor_q   <= '0;
			pos_q   <= '0;
			match_q <= 1'b1;
			high_q  <= '0;
			derr_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			xor_q   <= xor_d;
			pos_q   <= pos_d;
			match_q <= match_d;
			high_q  <= high_d;
			derr_q  <= derr_d;
		end
	end

endmodule

@@ design/nsc_out_reg.sv @@
module nsc_out_reg import nsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  nsc_res_t   res_in,
	input  logic       res_ready,
	output logic       res_valid,
	output logic [1:0] status,
	output logic [7:0] computed_sum,
	output logic [7:0] received_sum
);

	logic     valid_q;
	nsc_res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign res_valid    = valid_q;
	assign status       = res_q.status;
	assign computed_sum = res_q.computed_sum;
	assign received_sum = res_q.received_sum;

endmodule
